FILE: sv/ntgs_pkg.sv
package ntgs_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int MAX_NOTES = 63;
    localparam int NOTE_W = 7;

    // entry word, lowest bit up: address, mac, expiry, x, y, has_route, device, source, closed
    localparam int ENT_W = 32 + 48 + 32 + 16 + 16 + 1 + 8 + 32 + 1;

    typedef enum logic [2:0] {
        CMD_UPDATE   = 3'd0,
        CMD_UPDATE_P = 3'd1,
        CMD_IS_NB    = 3'd2,
        CMD_REMAIN   = 3'd3,
        CMD_TX_ERR   = 3'd4,
        CMD_BEST     = 3'd5,
        CMD_TICK     = 3'd6,
        CMD_NONE     = 3'd7
    } t_cmd;

    typedef struct packed {
        logic        closed;
        logic [31:0] source;
        logic [7:0]  device;
        logic        has_route;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic [31:0] expiry;
        logic [47:0] mac;
        logic [31:0] address;
    } t_entry;

    typedef struct packed {
        logic        kind;
        logic        found;
        logic [31:0] address;
        logic [31:0] remaining;
        logic [7:0]  device;
        logic [31:0] source;
        logic        full;
        logic        last;
    } t_result;
endpackage

FILE: sv/ntgs_ram.sv
module ntgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/ntgs_dist.sv
// Shared squared-distance unit: one multiply stage, one add stage.
module ntgs_dist (
    input  logic               i_clk,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by,
    output logic [33:0]        o_d2
);
    logic signed [16:0] w_dx, w_dy;
    logic [33:0] r_sx, r_sy;

    assign w_dx = 17'(i_ax) - 17'(i_bx);
    assign w_dy = 17'(i_ay) - 17'(i_by);

    always_ff @(posedge i_clk) begin
        r_sx  <= 34'(w_dx * w_dx);
        r_sy  <= 34'(w_dy * w_dy);
        o_d2  <= r_sx + r_sy;
    end
endmodule

FILE: sv/neighbor_table_greedy_select_core.sv
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      command request (tdata)
// m_axis    out  tvalid/tready      answers and link failure notices (tdata, tuser, tlast)
// cfg       in   i_cfg_we           report_link_failures
// An update that misses runs a match scan, then a purge pass that reads one entry a
// cycle, unless a notice holds it, and writes back each survivor that has to move.
// Queries, tx error and tick purge first and then scan. Best neighbor streams the
// current node and every valid entry through the two-stage distance unit. Each
// notice waits for the output register to drain. Reset is synchronous; valid
// entries are tracked by a fill count. Input is not ready until the answer is
// loaded into the output register.
module neighbor_table_greedy_select_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], now_time[34:3], neighbor_address[66:35], lifetime[98:67],
    // pos_x[114:99], pos_y[130:115], dest_x[146:131], dest_y[162:147],
    // hw_address[210:163], device_index[218:211], source_address[250:219]
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found[0], result_address[32:1], remaining_time[64:33], route_device[72:65],
    // route_source[104:73], table_full[105]
    output logic [111:0] m_axis_tdata,
    // kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    import ntgs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND, S_PURGE_RD, S_PURGE, S_NOTE, S_SEL, S_APPLY,
        S_BEST, S_ANSWER
    } t_state;

    t_state r_state;
    logic r_report;
    logic [255:0] r_in;
    logic [CNT_W-1:0] r_count, r_rd, r_wr;
    logic [NOTE_W-1:0] r_notes;
    logic r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    t_entry r_hit_ent;
    logic r_purged;
    logic r_full;
    logic r_best_ok;
    logic [33:0] r_best_d;
    t_entry r_best_ent;
    logic [2:0] r_pipe;
    logic [CNT_W-1:0] r_dcnt;
    logic r_pv0, r_pv1;
    t_entry r_pe0, r_pe1;
    logic [33:0] r_cur_d;

    logic [2:0]  w_cmd;
    logic [31:0] w_now, w_addr, w_life, w_src, w_exp;
    logic signed [15:0] w_px, w_py, w_dx, w_dy;
    logic [47:0] w_mac;
    logic [7:0]  w_dev;
    logic [32:0] w_sum;

    assign w_cmd  = r_in[2:0];
    assign w_now  = r_in[34:3];
    assign w_addr = r_in[66:35];
    assign w_life = r_in[98:67];
    assign w_px   = r_in[114:99];
    assign w_py   = r_in[130:115];
    assign w_dx   = r_in[146:131];
    assign w_dy   = r_in[162:147];
    assign w_mac  = r_in[210:163];
    assign w_dev  = r_in[218:211];
    assign w_src  = r_in[250:219];
    assign w_sum  = 33'(w_now) + 33'(w_life);
    assign w_exp  = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];

    logic ram_we;
    logic [IDX_W-1:0] ram_wa, ram_ra;
    t_entry ram_wd, ram_rd;

    ntgs_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    logic signed [15:0] d_ax, d_ay;
    logic [33:0] d_out;
    ntgs_dist u_dist (
        .i_clk(i_clk), .i_ax(d_ax), .i_ay(d_ay), .i_bx(w_dx), .i_by(w_dy), .o_d2(d_out)
    );

    // the same unit first measures the current node, then each entry
    assign d_ax = (r_state == S_BEST && r_dcnt == '0) ? w_px : ram_rd.x;
    assign d_ay = (r_state == S_BEST && r_dcnt == '0) ? w_py : ram_rd.y;

    logic w_doomed;
    t_entry w_fix;
    assign w_doomed = (ram_rd.expiry < w_now) || ram_rd.closed ||
                      (w_cmd == CMD_TX_ERR && ram_rd.mac == w_mac);
    always_comb begin
        w_fix = ram_rd;
        if (w_cmd == CMD_TX_ERR && ram_rd.mac == w_mac) w_fix.closed = 1'b1;
    end

    logic w_out_free;
    logic w_load;
    logic [111:0] w_res_data;
    logic w_res_kind, w_res_last;
    assign w_out_free = !m_axis_tvalid || m_axis_tready;
    assign w_load = w_out_free && (r_state == S_NOTE || r_state == S_ANSWER);
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        w_res_data = '0;
        w_res_kind = 1'b0;
        w_res_last = 1'b1;
        if (r_state == S_NOTE) begin
            w_res_kind = 1'b1;
            w_res_last = 1'b0;
            w_res_data[32:1] = r_hit_ent.address;
        end else begin
            case (w_cmd)
                CMD_UPDATE, CMD_UPDATE_P: begin
                    w_res_data[0] = !r_full;
                    w_res_data[105] = r_full;
                end
                CMD_IS_NB: w_res_data[0] = r_hit;
                CMD_REMAIN: begin
                    w_res_data[0] = r_hit;
                    if (r_hit) w_res_data[64:33] = r_hit_ent.expiry - w_now;
                end
                CMD_BEST: begin
                    w_res_data[0] = r_best_ok;
                    if (r_best_ok) begin
                        w_res_data[32:1] = r_best_ent.address;
                        w_res_data[72:65] = r_best_ent.device;
                        w_res_data[104:73] = r_best_ent.source;
                    end
                end
                default: ;
            endcase
        end
    end

    t_entry w_upd;
    always_comb begin
        w_upd = r_hit_ent;
        if (r_hit) begin
            if (w_exp > r_hit_ent.expiry) w_upd.expiry = w_exp;
            if (r_hit_ent.mac == '0) w_upd.mac = w_mac;
        end else begin
            w_upd = '0;
            w_upd.address = w_addr;
            w_upd.mac = w_mac;
            w_upd.expiry = w_exp;
        end
        if (w_cmd == CMD_UPDATE_P) begin
            w_upd.x = w_px;
            w_upd.y = w_py;
            w_upd.has_route = 1'b1;
            w_upd.device = w_dev;
            w_upd.source = w_src;
        end
    end

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_wr[IDX_W-1:0];
        ram_wd = w_fix;
        ram_ra = r_rd[IDX_W-1:0];
        if (r_state == S_PURGE && !w_doomed) begin
            ram_we = (r_wr != r_rd - 1'b1) || (w_cmd == CMD_TX_ERR);
        end
        if (r_state == S_APPLY && (r_hit || r_count != CNT_W'(TABLE_DEPTH))) begin
            ram_we = 1'b1;
            ram_wa = r_hit ? r_hit_idx : r_count[IDX_W-1:0];
            ram_wd = w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_report <= 1'b0;
            r_count <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_report <= i_cfg_wdata;
            if (w_load) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tuser <= w_res_kind;
                m_axis_tlast <= w_res_last;
                m_axis_tdata <= w_res_data;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in <= s_axis_tdata;
                        r_rd <= '0;
                        r_wr <= '0;
                        r_hit <= 1'b0;
                        r_purged <= 1'b0;
                        r_full <= 1'b0;
                        r_notes <= '0;
                        r_state <= S_FIND_RD;
                    end
                end
                S_FIND_RD: begin
                    // prime the read for either scan kind; best neighbor reads entry 0 again
                    r_rd <= (w_cmd == CMD_BEST) ? CNT_W'(0) : CNT_W'(1);
                    r_dcnt <= '0;
                    r_pipe <= '0;
                    r_best_ok <= 1'b0;
                    r_pv0 <= 1'b0; r_pv1 <= 1'b0;
                    if (r_hit || (r_purged && (w_cmd == CMD_UPDATE ||
                                               w_cmd == CMD_UPDATE_P))) begin
                        r_state <= S_APPLY;
                    end else if (w_cmd == CMD_BEST) begin
                        r_state <= S_BEST;
                    end else if (w_cmd == CMD_NONE) begin
                        r_state <= S_ANSWER;
                    end else if ((w_cmd == CMD_UPDATE || w_cmd == CMD_UPDATE_P ||
                                  r_purged) && r_count != '0) begin
                        r_state <= S_FIND;
                    end else if (!r_purged && w_cmd != CMD_UPDATE &&
                                 w_cmd != CMD_UPDATE_P) begin
                        r_state <= (r_count != '0) ? S_PURGE : S_SEL;
                        r_purged <= 1'b1;
                    end else begin
                        r_state <= S_SEL;
                    end
                end
                S_FIND: begin
                    if (ram_rd.address == w_addr) begin
                        r_hit <= 1'b1;
                        r_hit_idx <= IDX_W'(r_rd - 1'b1);
                        r_hit_ent <= ram_rd;
                        r_state <= S_SEL;
                    end else if (r_rd == r_count) begin
                        r_state <= S_SEL;
                    end else begin
                        r_rd <= r_rd + 1'b1;
                    end
                end
                S_SEL: begin
                    // after find: miss on update means purge, then insert
                    if ((w_cmd == CMD_UPDATE || w_cmd == CMD_UPDATE_P) &&
                        !r_hit && !r_purged) begin
                        r_purged <= 1'b1;
                        r_rd <= '0;
                        r_state <= (r_count != '0) ? S_PURGE_RD : S_APPLY;
                    end else if (w_cmd == CMD_UPDATE || w_cmd == CMD_UPDATE_P) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_state <= S_ANSWER;
                    end
                end
                S_PURGE_RD: begin
                    r_rd <= CNT_W'(1);
                    r_wr <= '0;
                    r_state <= S_PURGE;
                end
                S_PURGE: begin
                    if (w_doomed) begin
                        if (r_report && r_notes != NOTE_W'(MAX_NOTES)) begin
                            r_state <= S_NOTE;
                            r_hit_ent <= ram_rd;
                        end
                    end else begin
                        r_wr <= r_wr + 1'b1;
                    end
                    if (!(w_doomed && r_report && r_notes != NOTE_W'(MAX_NOTES))) begin
                        if (r_rd == r_count) begin
                            r_count <= w_doomed ? r_wr : r_wr + 1'b1;
                            r_rd <= '0;
                            r_state <= S_FIND_RD;
                        end else begin
                            r_rd <= r_rd + 1'b1;
                        end
                    end
                end
                S_NOTE: begin
                    // the next entry is already on the read port; resume the pass
                    if (w_out_free) begin
                        r_notes <= r_notes + 1'b1;
                        if (r_rd == r_count) begin
                            r_count <= r_wr;
                            r_rd <= '0;
                            r_state <= S_FIND_RD;
                        end else begin
                            r_rd <= r_rd + 1'b1;
                            r_state <= S_PURGE;
                        end
                    end
                end
                S_APPLY: begin
                    if (!r_hit) begin
                        if (r_count == CNT_W'(TABLE_DEPTH)) r_full <= 1'b1;
                        else r_count <= r_count + 1'b1;
                    end
                    r_state <= S_ANSWER;
                end
                S_BEST: begin
                    // pipeline: entries launch each cycle, results land alongside r_pv1 and r_pe1
                    r_pv0 <= (r_dcnt != '0) && (r_dcnt <= r_count) && ram_rd.has_route;
                    r_pe0 <= ram_rd;
                    r_pv1 <= r_pv0; r_pe1 <= r_pe0;
                    if (r_dcnt <= r_count) begin
                        r_rd <= r_rd + 1'b1;
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                    r_pipe <= {r_pipe[1:0], r_dcnt == '0};
                    if (r_pipe[1]) r_cur_d <= d_out;
                    if (r_pv1 && d_out < r_cur_d && (!r_best_ok || d_out < r_best_d)) begin
                        r_best_ok <= 1'b1;
                        r_best_d <= d_out;
                        r_best_ent <= r_pe1;
                    end
                    if (r_dcnt > r_count && !r_pv0 && !r_pv1 && r_pipe == '0) begin
                        r_state <= S_ANSWER;
                    end
                end
                S_ANSWER: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/ntgs_checker.sv
module ntgs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tuser,
    input logic m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
    a_notice_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast) else $error("notice marked last");
    a_answer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast) else $error("answer not last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
endmodule

bind neighbor_table_greedy_select_core ntgs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

FILE: test/neighbor_table_checker.sv
module neighbor_table_checker
    import ntgs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [255:0] i_req_data,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [111:0] i_res_data,
    input  logic         i_res_kind,
    input  logic         i_res_last,
    output int           o_fail_count,
    output int           o_pending
);
    logic        nb_valid  [TABLE_DEPTH];
    logic [31:0] nb_addr   [TABLE_DEPTH];
    logic [47:0] nb_mac    [TABLE_DEPTH];
    logic [31:0] nb_expiry [TABLE_DEPTH];
    logic signed [15:0] nb_x [TABLE_DEPTH];
    logic signed [15:0] nb_y [TABLE_DEPTH];
    logic        nb_routed [TABLE_DEPTH];
    logic [7:0]  nb_dev    [TABLE_DEPTH];
    logic [31:0] nb_src    [TABLE_DEPTH];
    logic        nb_closed [TABLE_DEPTH];
    logic        notify_on;
    t_result     answer_q[$];
    int          note_cnt;

    function automatic t_result blank_result();
        t_result r;
        r = '0;
        return r;
    endfunction

    // Drop expired or closed entries, keep survivors in order, queue notices.
    task automatic purge_table(input logic [31:0] now);
        int w;
        t_result r;
        w = 0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (!nb_valid[k]) continue;
            if (nb_expiry[k] < now || nb_closed[k]) begin
                if (notify_on && note_cnt < MAX_NOTES) begin
                    r = blank_result();
                    r.kind = 1'b1;
                    r.address = nb_addr[k];
                    answer_q = {answer_q, r};
                    note_cnt++;
                end
                continue;
            end
            nb_valid[w] = 1'b1; nb_addr[w] = nb_addr[k]; nb_mac[w] = nb_mac[k];
            nb_expiry[w] = nb_expiry[k]; nb_x[w] = nb_x[k]; nb_y[w] = nb_y[k];
            nb_routed[w] = nb_routed[k]; nb_dev[w] = nb_dev[k];
            nb_src[w] = nb_src[k]; nb_closed[w] = nb_closed[k];
            w++;
        end
        for (int k = w; k < TABLE_DEPTH; k++) nb_valid[k] = 1'b0;
    endtask

    function automatic int lookup(input logic [31:0] a);
        for (int k = 0; k < TABLE_DEPTH; k++)
            if (nb_valid[k] && nb_addr[k] == a) return k;
        return -1;
    endfunction

    function automatic logic [63:0] sq_dist(input logic signed [15:0] ax,
        input logic signed [15:0] ay, input logic signed [15:0] bx,
        input logic signed [15:0] by);
        logic signed [63:0] ddx, ddy;
        ddx = 64'(ax) - 64'(bx);
        ddy = 64'(ay) - 64'(by);
        return ddx * ddx + ddy * ddy;
    endfunction

    task automatic predict_request(input logic [255:0] d);
        t_cmd cmd;
        logic [31:0] now, addr, life, expiry;
        logic signed [15:0] px, py, tx, ty;
        logic [47:0] mac;
        logic [63:0] cur, best, dd;
        int i, pick;
        t_result r;
        cmd = t_cmd'(d[2:0]);
        now = d[34:3]; addr = d[66:35]; life = d[98:67];
        px = d[114:99]; py = d[130:115]; tx = d[146:131]; ty = d[162:147];
        mac = d[210:163];
        expiry = (life > 32'hFFFF_FFFF - now) ? 32'hFFFF_FFFF : now + life;
        note_cnt = 0;
        r = blank_result();
        r.last = 1'b1;
        case (cmd)
            CMD_UPDATE, CMD_UPDATE_P: begin
                r.found = 1'b1;
                i = lookup(addr);
                if (i >= 0) begin
                    if (expiry > nb_expiry[i]) nb_expiry[i] = expiry;
                    if (nb_mac[i] == '0) nb_mac[i] = mac;
                end else begin
                    purge_table(now);
                    i = 0;
                    while (i < TABLE_DEPTH && nb_valid[i]) i++;
                    if (i >= TABLE_DEPTH) begin
                        r.found = 1'b0;
                        r.full = 1'b1;
                        i = -1;
                    end else begin
                        nb_valid[i] = 1'b1; nb_addr[i] = addr; nb_mac[i] = mac;
                        nb_expiry[i] = expiry; nb_x[i] = '0; nb_y[i] = '0;
                        nb_routed[i] = 1'b0; nb_dev[i] = '0; nb_src[i] = '0;
                        nb_closed[i] = 1'b0;
                    end
                end
                if (cmd == CMD_UPDATE_P && i >= 0) begin
                    nb_x[i] = px; nb_y[i] = py; nb_routed[i] = 1'b1;
                    nb_dev[i] = d[218:211]; nb_src[i] = d[250:219];
                end
            end
            CMD_IS_NB, CMD_REMAIN: begin
                purge_table(now);
                i = lookup(addr);
                if (i >= 0) begin
                    r.found = 1'b1;
                    if (cmd == CMD_REMAIN) r.remaining = nb_expiry[i] - now;
                end
            end
            CMD_TX_ERR: begin
                for (int k = 0; k < TABLE_DEPTH; k++)
                    if (nb_valid[k] && nb_mac[k] == mac) nb_closed[k] = 1'b1;
                purge_table(now);
            end
            CMD_BEST: begin
                cur = sq_dist(px, py, tx, ty);
                best = '0;
                pick = -1;
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    if (!nb_valid[k] || !nb_routed[k]) continue;
                    dd = sq_dist(nb_x[k], nb_y[k], tx, ty);
                    if (dd < cur && (pick < 0 || dd < best)) begin
                        best = dd;
                        pick = k;
                    end
                end
                if (pick >= 0) begin
                    r.found = 1'b1;
                    r.address = nb_addr[pick];
                    r.device = nb_dev[pick];
                    r.source = nb_src[pick];
                end
            end
            CMD_TICK: purge_table(now);
            default: ;
        endcase
        answer_q = {answer_q, r};
    endtask

    task automatic compare_result();
        t_result got, want;
        got.kind = i_res_kind; got.found = i_res_data[0];
        got.address = i_res_data[32:1]; got.remaining = i_res_data[64:33];
        got.device = i_res_data[72:65]; got.source = i_res_data[104:73];
        got.full = i_res_data[105]; got.last = i_res_last;
        if (answer_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            o_fail_count++;
        end else begin
            want = answer_q.pop_front();
            if (got !== want) begin
                $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) nb_valid[k] = 1'b0;
            notify_on = 1'b0;
            answer_q.delete();
            o_fail_count = 0;
        end else begin
            // Outputs reflect the request accepted in an earlier cycle, so check first.
            if (i_res_valid && i_res_ready) compare_result();
            if (i_cfg_we) notify_on = i_cfg_wdata;
            if (i_req_valid && i_req_ready) predict_request(i_req_data);
        end
        o_pending = answer_q.size();
    end
endmodule

FILE: test/neighbor_table_greedy_select_core_test.sv
module neighbor_table_greedy_select_core_test;
    import ntgs_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_wdata = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    bit           sink_hold = 1'b0;
    logic [31:0]  addr_pool[8];
    logic [47:0]  mac_pool[4];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    neighbor_table_greedy_select_core u_top (.*);

    neighbor_table_checker u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_kind(m_axis_tuser),
        .i_res_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int rand_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                           : $urandom_range(0, 3);
    endfunction

    // Sink: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : rand_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog: no handshake for too long ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("neighbor_table_greedy_select_core_test failed");
            $finish;
        end
    end

    // Hold valid after the accept; the next request or a drain replaces it.
    task automatic send_request(input t_cmd cmd, input logic [31:0] now,
        input logic [31:0] addr, input logic [31:0] life, input logic [15:0] px,
        input logic [15:0] py, input logic [15:0] tx, input logic [15:0] ty,
        input logic [47:0] mac, input logic [7:0] dev, input logic [31:0] src,
        input bit gaps);
        int gap;
        gap = gaps ? rand_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, src, dev, mac, ty, tx, py, px, life, addr, now, cmd};
        @(posedge i_clk iff s_axis_tready);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_notify(input logic v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_request(input logic [31:0] now, input bit gaps);
        t_cmd cmd;
        logic [31:0] addr, life;
        logic [47:0] mac;
        cmd = t_cmd'($urandom_range(0, 7));
        if ($urandom_range(0, 2) != 0)
            cmd = ($urandom_range(0, 1) == 0) ? CMD_UPDATE_P : CMD_BEST;
        addr = ($urandom_range(0, 9) == 0) ? $urandom() : addr_pool[$urandom_range(0, 7)];
        life = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 200);
        mac = ($urandom_range(0, 5) == 0) ? 48'({$urandom(), $urandom()})
                                          : mac_pool[$urandom_range(0, 3)];
        send_request(cmd, now, addr, life, 16'($urandom()), 16'($urandom()),
                     16'($urandom()), 16'($urandom()), mac, 8'($urandom()), $urandom(),
                     gaps);
    endtask

    initial begin
        logic [31:0] now;
        for (int k = 0; k < 8; k++) addr_pool[k] = $urandom();
        mac_pool[0] = '0;
        for (int k = 1; k < 4; k++) mac_pool[k] = 48'({$urandom(), $urandom()});
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_notify(1'b1);

        // Directed: extremes, every command, saturation, zero MAC, unused code.
        send_request(CMD_UPDATE, 32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, '0,
                     48'd0, 8'd0, 32'd0, 1'b0);
        send_request(CMD_UPDATE_P, 32'd10, 32'd1, 32'd50, 16'h7FFF, 16'h8000, '0, '0,
                     48'hFFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_request(CMD_UPDATE_P, 32'd10, 32'd2, 32'd50, 16'h8000, 16'h7FFF, '0, '0,
                     48'h1234, 8'h01, 32'h1, 1'b0);
        send_request(CMD_UPDATE, 32'd11, 32'hFFFF_FFFF, 32'd5, '0, '0, '0, '0,
                     48'hABCD, '0, '0, 1'b0);
        send_request(CMD_BEST, 32'd12, '0, '0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                     '0, '0, '0, 1'b0);
        send_request(CMD_BEST, 32'd12, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_request(CMD_IS_NB, 32'd13, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_request(CMD_REMAIN, 32'd14, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0, '0,
                     1'b0);
        send_request(CMD_REMAIN, 32'd14, 32'd77, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_request(CMD_TX_ERR, 32'd15, '0, '0, '0, '0, '0, '0, 48'h1234, '0, '0, 1'b0);
        send_request(CMD_TX_ERR, 32'd15, '0, '0, '0, '0, '0, '0, 48'hABCD, '0, '0, 1'b0);
        send_request(CMD_TICK, 32'd100, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_request(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 8'hFF,
                     32'hFFFF_FFFF, 1'b0);
        // Fill the table past capacity, then purge it all, with notices up to the per-request limit.
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
            send_request(CMD_UPDATE, 32'd200, 32'h100 + k, 32'd10, '0, '0, '0, '0,
                         48'd0, '0, '0, k == 5);
        send_request(CMD_TX_ERR, 32'd201, '0, '0, '0, '0, '0, '0, 48'd0, '0, '0, 1'b0);
        drain_and_settle();

        // Random phase, notices on, with one long sink hold-off.
        now = 32'd300;
        sink_hold = 1'b1;
        for (int k = 0; k < 30; k++) begin
            now = now + $urandom_range(0, 20);
            random_request(now, k > 10);
        end
        drain_and_settle();
        write_notify(1'b0);
        for (int k = 0; k < 25; k++) begin
            now = now + $urandom_range(0, 20);
            random_request(now, 1'b1);
        end
        drain_and_settle();
        write_notify(1'b1);
        for (int k = 0; k < 25; k++) begin
            now = ($urandom_range(0, 19) == 0) ? $urandom() : now + $urandom_range(0, 20);
            random_request(now, 1'b1);
        end
        drain_and_settle();

        if (fail_count == 0)
            $display("neighbor_table_greedy_select_core_test passed");
        else
            $display("neighbor_table_greedy_select_core_test failed");
        $finish;
    end
endmodule

FILE: sim.f
sv/ntgs_pkg.sv
sv/ntgs_ram.sv
sv/ntgs_dist.sv
sv/neighbor_table_greedy_select_core.sv
sv/ntgs_checker.sv
test/neighbor_table_checker.sv
test/neighbor_table_greedy_select_core_test.sv
